>>> sv/brbm_pkg.sv
// ----------------------------------------------------------------------------
// brbm_pkg
// Shared types and constants of the bounded byte RAM: the memory geometry,
// the operation codes and the per-request bank decode bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package brbm_pkg;

   localparam int MEM_BYTES   = 65536;
   localparam int NUM_BANKS   = 8;
   localparam int LANE_W      = $clog2(NUM_BANKS);
   localparam int BANK_DEPTH  = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
   localparam int ROW_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int SIZE_W      = 17;
   localparam int ADDR_W      = 64;
   localparam int DATA_W      = 64;
   localparam int WIDTH_W     = 2;
   localparam int NBYTES_W    = LANE_W + 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CHECK = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [NUM_BANKS-1:0]            bank_en;
      logic [NUM_BANKS-1:0][ROW_W-1:0] bank_row;
      logic [NUM_BANKS-1:0][7:0]       bank_wdata;
      logic                            read_err;
      logic                            write_err;
      logic                            span_fits;
   } dec_type;

endpackage

`default_nettype wire

>>> sv/brbm_bank.sv
// ----------------------------------------------------------------------------
// brbm_bank
// One byte-wide bank of the interleaved store, with one write port and one
// read port whose data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brbm_bank (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [brbm_pkg::ROW_W-1:0] wr_row,
   input  wire logic [7:0]                 wr_data,
   input  wire logic                       rd_en,
   input  wire logic [brbm_pkg::ROW_W-1:0] rd_row,
   output logic      [7:0]                 rd_data
);
   import brbm_pkg::*;

   logic [7:0] store_ff [BANK_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/brbm_decode.sv
// ----------------------------------------------------------------------------
// brbm_decode
// Maps one request onto the eight banks: the row, the byte to write and the
// enable of each bank, and the range flags of the request.
// ----------------------------------------------------------------------------
`default_nettype none

module brbm_decode (
   input  wire logic [brbm_pkg::ADDR_W-1:0]  address,
   input  wire logic [brbm_pkg::WIDTH_W-1:0] width_code,
   input  wire logic [brbm_pkg::DATA_W-1:0]  write_value,
   input  wire logic [brbm_pkg::ADDR_W-1:0]  span_length,
   input  wire logic [brbm_pkg::SIZE_W-1:0]  limit,
   output brbm_pkg::dec_type                 dec
);
   import brbm_pkg::*;

   logic [NBYTES_W-1:0] nbytes;
   logic [ADDR_W-1:0]   limit_wide;
   logic [ADDR_W-1:0]   high_addr;
   logic                base_inside;
   logic [SIZE_W-1:0]   room;

   assign nbytes      = NBYTES_W'(1) << width_code;
   assign limit_wide  = ADDR_W'(limit);
   assign high_addr   = address + ADDR_W'(nbytes - NBYTES_W'(1));
   assign base_inside = address < limit_wide;
   assign room        = limit - address[SIZE_W-1:0];

   always_comb begin
      logic [LANE_W-1:0] offset;
      logic [ADDR_W-1:0] byte_addr;
      dec = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         offset             = LANE_W'(b) - address[LANE_W-1:0];
         byte_addr          = address + ADDR_W'(offset);
         dec.bank_en[b]     = ({1'b0, offset} < nbytes) && (byte_addr < limit_wide);
         dec.bank_row[b]    = byte_addr[ROW_W+LANE_W-1:LANE_W];
         dec.bank_wdata[b]  = 8'(write_value >> {offset, 3'b000});
      end
      dec.read_err  = !(high_addr < limit_wide);
      dec.write_err = !base_inside;
      dec.span_fits = base_inside && (span_length <= ADDR_W'(room));
   end

endmodule

`default_nettype wire

>>> sv/bounded_byte_ram_multiwidth.sv
// ----------------------------------------------------------------------------
// bounded_byte_ram_multiwidth
// Byte-addressed little-endian RAM with 1, 2, 4 and 8 byte accesses at any
// alignment, bounded by a programmable size, plus a span range check.
//
//   Channel  Direction  Payload
//   req      in         op, address, width_code, write_value, span_length
//   rsp      out        read_value, range_error, span_fits
//   csr      in         size_in_use
//
// One request per cycle is sustained while responses are taken. An accepted
// request passes through the bank stage, where the banks are read, and then
// the response register. The store is eight byte banks, so any access touches
// each bank at most once and is served by a single read or write of each bank.
// Reset sets the size to 65536 and empties the pipeline; the store itself
// is not cleared. A stalled response holds the pipeline stage behind it,
// and a new request is taken only when that stage can move.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_byte_ram_multiwidth (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic [brbm_pkg::ADDR_W-1:0]   req_address,
   input  wire logic [brbm_pkg::WIDTH_W-1:0]  req_width_code,
   input  wire logic [brbm_pkg::DATA_W-1:0]   req_write_value,
   input  wire logic [brbm_pkg::ADDR_W-1:0]   req_span_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [brbm_pkg::DATA_W-1:0]   rsp_read_value,
   output logic                               rsp_range_error,
   output logic                               rsp_span_fits,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [brbm_pkg::SIZE_W-1:0]   csr_size_in_use
);
   import brbm_pkg::*;

   logic [SIZE_W-1:0]          size_ff;
   logic [SIZE_W-1:0]          limit;
   dec_type                    dec;
   op_type                     op;
   logic                       req_fire;
   logic                       s1_adv;
   logic [NUM_BANKS-1:0][7:0]  bank_rd;

   logic                       s1_valid_ff, s1_valid_in;
   logic [LANE_W-1:0]          s1_base_ff;
   logic [NUM_BANKS-1:0]       s1_rd_mask_ff, s1_rd_mask_in;
   logic                       s1_err_ff, s1_err_in;
   logic                       s1_fits_ff, s1_fits_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]          rsp_value_ff, rsp_value_in;
   logic                       rsp_err_ff;
   logic                       rsp_fits_ff;

   assign csr_ready = 1'b1;
   assign limit = (ADDR_W'(size_ff) > ADDR_W'(MEM_BYTES)) ? SIZE_W'(MEM_BYTES) : size_ff;
   assign op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_size_in_use;
      end
   end

   brbm_decode u_decode (
      .address     (req_address),
      .width_code  (req_width_code),
      .write_value (req_write_value),
      .span_length (req_span_length),
      .limit       (limit),
      .dec         (dec)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      brbm_bank u_bank (
         .clock   (clock),
         .wr_en   (req_fire && (op == OP_WRITE) && dec.bank_en[b]),
         .wr_row  (dec.bank_row[b]),
         .wr_data (dec.bank_wdata[b]),
         .rd_en   (req_fire),
         .rd_row  (dec.bank_row[b]),
         .rd_data (bank_rd[b])
      );
   end

   always_comb begin
      s1_rd_mask_in = '0;
      s1_err_in     = 1'b0;
      s1_fits_in    = 1'b0;
      unique case (op)
         OP_READ: begin
            s1_rd_mask_in = dec.bank_en;
            s1_err_in     = dec.read_err;
         end
         OP_WRITE: begin
            s1_err_in = dec.write_err;
         end
         OP_CHECK: begin
            s1_fits_in = dec.span_fits;
         end
         default: begin
         end
      endcase
   end

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_base_ff    <= req_address[LANE_W-1:0];
         s1_rd_mask_ff <= s1_rd_mask_in;
         s1_err_ff     <= s1_err_in;
         s1_fits_ff    <= s1_fits_in;
      end
   end

   always_comb begin
      logic [LANE_W-1:0] bank;
      rsp_value_in = '0;
      for (int i = 0; i < NUM_BANKS; i++) begin
         bank = s1_base_ff + LANE_W'(i);
         if (s1_rd_mask_ff[bank]) begin
            rsp_value_in[8*i +: 8] = bank_rd[bank];
         end
      end
   end

   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv) begin
         rsp_value_ff <= rsp_value_in;
         rsp_err_ff   <= s1_err_ff;
         rsp_fits_ff  <= s1_fits_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_range_error = rsp_err_ff;
   assign rsp_span_fits   = rsp_fits_ff;

`ifndef ASSERT_OFF
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("Pending request dropped from the bank stage.");

   a_no_read_mask: assert property (@(posedge clock) disable iff (reset)
      req_fire && (op != OP_READ) |=> s1_rd_mask_ff == '0)
      else $error("Read mask set for a request that is not a read.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_err_ff && rsp_fits_ff))
      else $error("Response carries both a range error and a fitting span.");

   a_accept_when_free: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("Accepted request missing from the bank stage.");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the bounded byte RAM. A stimulus process
// queues read, write, check and unused requests in phases, one size
// setting per phase. It writes the size only while the block is idle. A
// driver and a monitor run on the clock with random gaps and stalls. A
// shadow copy of the store predicts every response, which is checked field
// by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   import brbm_pkg::*;

   typedef struct {
      op_type      op;
      logic [63:0] address;
      logic [1:0]  width_code;
      logic [63:0] write_value;
      logic [63:0] span_length;
   } ram_req_type;

   typedef struct {
      logic [63:0] read_value;
      logic        range_error;
      logic        span_fits;
   } ram_resp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_op = 2'd0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [WIDTH_W-1:0]  req_width_code = '0;
   logic [DATA_W-1:0]   req_write_value = '0;
   logic [ADDR_W-1:0]   req_span_length = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_read_value;
   logic                rsp_range_error;
   logic                rsp_span_fits;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_size_in_use = '0;

   ram_req_type         pending_requests[$];
   ram_resp_type        expected_responses[$];
   logic [63:0]         write_bases[$];
   logic [7:0]          shadow_mem [MEM_BYTES];
   bit                  byte_written [MEM_BYTES];
   logic [SIZE_W-1:0]   shadow_size = SIZE_RESET;
   int                  mismatch_count = 0;
   bit                  no_idle = 1'b0;
   int                  req_gap = 0;
   int                  rsp_wait = 0;

   bounded_byte_ram_multiwidth DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_address     (req_address),
      .req_width_code  (req_width_code),
      .req_write_value (req_write_value),
      .req_span_length (req_span_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_range_error (rsp_range_error),
      .rsp_span_fits   (rsp_span_fits),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_size_in_use (csr_size_in_use)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] size_limit();
      return (64'(shadow_size) > 64'(MEM_BYTES)) ? 64'(MEM_BYTES) : 64'(shadow_size);
   endfunction

   function automatic ram_resp_type predict_access(ram_req_type r);
      ram_resp_type res;
      logic [63:0]  lim;
      logic [63:0]  a;
      int           nbytes;
      res.read_value  = '0;
      res.range_error = 1'b0;
      res.span_fits   = 1'b0;
      lim    = size_limit();
      nbytes = 1 << r.width_code;
      case (r.op)
         OP_READ: begin
            for (int i = 0; i < nbytes; i++) begin
               a = r.address + 64'(i);
               if (a < lim) res.read_value[8*i +: 8] = shadow_mem[a[15:0]];
            end
            res.range_error = !((r.address + 64'(nbytes - 1)) < lim);
         end
         OP_WRITE: begin
            for (int i = 0; i < nbytes; i++) begin
               a = r.address + 64'(i);
               if (a < lim) shadow_mem[a[15:0]] = r.write_value[8*i +: 8];
            end
            res.range_error = !(r.address < lim);
         end
         OP_CHECK: begin
            res.span_fits = (r.address < lim) && (r.span_length <= lim - r.address);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic bit read_is_safe(logic [63:0] address, logic [1:0] width_code);
      logic [63:0] lim;
      logic [63:0] a;
      lim = size_limit();
      for (int i = 0; i < (1 << width_code); i++) begin
         a = address + 64'(i);
         if (a < lim && !byte_written[a[15:0]]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic queue_request(op_type op, logic [63:0] address, logic [1:0] width_code,
                                logic [63:0] write_value, logic [63:0] span_length);
      ram_req_type item;
      logic [63:0] lim;
      logic [63:0] a;
      lim              = size_limit();
      item.op          = op;
      item.address     = address;
      item.width_code  = width_code;
      item.write_value = write_value;
      item.span_length = span_length;
      if (op == OP_WRITE) begin
         for (int i = 0; i < (1 << width_code); i++) begin
            a = address + 64'(i);
            if (a < lim) byte_written[a[15:0]] = 1'b1;
         end
         write_bases.push_back(address);
      end
      pending_requests.push_back(item);
   endtask

   task automatic queue_random_requests(int count);
      logic [63:0] lim;
      logic [63:0] addr;
      logic [63:0] span;
      logic [1:0]  wc;
      op_type      op;
      int          roll;
      lim = size_limit();
      repeat (count) begin
         roll = $urandom_range(0, 99);
         wc   = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: addr = 64'($urandom_range(0, 32'(lim) + 15));
            5, 6:          addr = lim + 64'($urandom_range(0, 16)) - 64'd8;
            7:             addr = 64'hFFFF_FFFF_FFFF_FFF8 + 64'($urandom_range(0, 7));
            8:             addr = 64'(MEM_BYTES) + 64'($urandom_range(0, 16)) - 64'd8;
            default:       addr = {$urandom, $urandom};
         endcase
         case ($urandom_range(0, 3))
            0:       span = 64'($urandom_range(0, 9));
            1:       span = lim - addr + 64'($urandom_range(0, 2)) - 64'd1;
            2:       span = {$urandom, $urandom};
            default: span = '1;
         endcase
         if (roll < 40) op = OP_READ;
         else if (roll < 75) op = OP_WRITE;
         else if (roll < 95) op = OP_CHECK;
         else op = OP_NONE;
         if (op == OP_READ && roll < 30 && write_bases.size() != 0)
            addr = write_bases[$urandom_range(0, write_bases.size() - 1)]
                   + 64'($urandom_range(0, 6)) - 64'd3;
         if (op == OP_READ && !read_is_safe(addr, wc)) op = OP_WRITE;
         queue_request(op, addr, wc, {$urandom, $urandom}, span);
      end
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      mismatch_count++;
   endtask

   task automatic wait_until_idle();
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin : driver
      ram_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            item.op          = op_type'(req_op);
            item.address     = req_address;
            item.width_code  = req_width_code;
            item.write_value = req_write_value;
            item.span_length = req_span_length;
            expected_responses.push_back(predict_access(item));
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (pending_requests.size() != 0) begin
               item = pending_requests.pop_front();
               req_op          <= item.op;
               req_address     <= item.address;
               req_width_code  <= item.width_code;
               req_write_value <= item.write_value;
               req_span_length <= item.span_length;
               req_valid       <= 1'b1;
               req_gap         <= no_idle ? 0 : $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_ready
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         w = no_idle ? 0 : $urandom_range(0, 3);
         rsp_wait  <= w;
         rsp_ready <= (w == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      ram_resp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response without request", rsp_read_value, '0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_read_value !== want.read_value)
               report_mismatch("read_value", rsp_read_value, want.read_value);
            if (rsp_range_error !== want.range_error)
               report_mismatch("range_error", 64'(rsp_range_error), 64'(want.range_error));
            if (rsp_span_fits !== want.span_fits)
               report_mismatch("span_fits", 64'(rsp_span_fits), 64'(want.span_fits));
         end
      end
   end

   initial begin : stimulus
      logic [SIZE_W-1:0] phase_sizes [9];
      phase_sizes = '{17'd0, 17'd1, 17'd8, 17'd65535, 17'd131071, 17'd65536,
                      17'd70000, 17'd4096, 17'd65536};
      phase_sizes[7] = SIZE_W'($urandom_range(0, 131071));
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_request(OP_WRITE, 64'd0, 2'd3, '1, '0);
      queue_request(OP_READ, 64'd0, 2'd0, '0, '0);
      queue_request(OP_READ, 64'd1, 2'd1, '0, '0);
      queue_request(OP_READ, 64'd2, 2'd2, '0, '0);
      queue_request(OP_READ, 64'd0, 2'd3, '0, '0);
      queue_request(OP_WRITE, 64'd0, 2'd3, '0, '0);
      queue_request(OP_READ, 64'd0, 2'd3, '0, '0);
      queue_request(OP_WRITE, 64'd3, 2'd2, 64'h0123_4567_89AB_CDEF, '0);
      queue_request(OP_READ, 64'd0, 2'd3, '0, '0);
      queue_request(OP_WRITE, 64'd65535, 2'd3, 64'hA5A5_5A5A_C3C3_3C3C, '0);
      queue_request(OP_READ, 64'd65535, 2'd0, '0, '0);
      queue_request(OP_READ, 64'd65535, 2'd1, '0, '0);
      queue_request(OP_WRITE, 64'd65536, 2'd0, 64'h0000_0000_0000_0077, '0);
      queue_request(OP_WRITE, '1, 2'd3, 64'h8877_6655_4433_2211, '0);
      queue_request(OP_READ, 64'hFFFF_FFFF_FFFF_FFFE, 2'd3, '0, '0);
      queue_request(OP_READ, '1, 2'd0, '0, '0);
      queue_request(OP_CHECK, 64'd0, 2'd0, '0, 64'd0);
      queue_request(OP_CHECK, 64'd0, 2'd0, '0, 64'd65536);
      queue_request(OP_CHECK, 64'd0, 2'd0, '0, 64'd65537);
      queue_request(OP_CHECK, 64'd65535, 2'd0, '0, 64'd1);
      queue_request(OP_CHECK, 64'd65536, 2'd0, '0, 64'd0);
      queue_request(OP_CHECK, '1, 2'd3, '0, '1);
      queue_request(OP_CHECK, 64'd100, 2'd0, '0, '1);
      queue_request(OP_NONE, '1, 2'd3, '1, '1);
      queue_random_requests(45);

      foreach (phase_sizes[p]) begin
         wait_until_idle();
         repeat (4) @(posedge clock);
         csr_valid       <= 1'b1;
         csr_size_in_use <= phase_sizes[p];
         do @(posedge clock); while (!csr_ready);
         csr_valid   <= 1'b0;
         shadow_size  = phase_sizes[p];
         @(negedge clock);
         no_idle = (p == 2 || p == 6);
         queue_random_requests(45);
      end

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (expected_responses.size() != 0)
         report_mismatch("responses never received", 64'(expected_responses.size()), '0);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("tb failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
sv/brbm_pkg.sv
sv/brbm_bank.sv
sv/brbm_decode.sv
sv/bounded_byte_ram_multiwidth.sv
tb/tb.sv
